// ----- src/cdac_pkg.sv -----
// shared types, constants and table-building functions of the cosine dac code generator
package cdac_pkg;

  // field and register widths
  localparam int TIME_W     = 32;
  localparam int FREQ_W     = 20;
  localparam int MV_W       = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd2;

  // register values after reset
  localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd9800;
  localparam logic [MV_W-1:0]   LOW_RESET  = 12'd0;
  localparam logic [MV_W-1:0]   HIGH_RESET = 12'd2800;

  // one period in units of centihertz times microseconds
  localparam int               PERIOD_W = 27;
  localparam logic [PERIOD_W-1:0] PERIOD = 27'd100000000;

  // reciprocal of the period for the modulo step, applied to the top bits of the product
  localparam int          RECIP_SHIFT   = 32;
  localparam int          MOD_LOW_BITS  = 26;
  localparam logic [31:0] MOD_RECIP     = 32'((64'd1 << 58) / 64'd100000000);
  localparam int          REM_W         = 28;

  // amplitude scale and the code denominator 32767 * 6600
  localparam int              AMP_W     = 15;
  localparam int              UPDN_W    = 16;
  localparam logic [UPDN_W-1:0] AMP_FULL = 16'd32767;
  localparam int              DEN_W     = 28;
  localparam logic [DEN_W-1:0] DEN      = 28'(32767 * 6600);
  localparam logic [DEN_W-1:0] HALF_DEN = DEN >> 1;
  localparam int              DEN_LOW_BITS = 26;
  localparam logic [31:0]     DEN_RECIP = 32'((64'd1 << 58) / 64'(32767 * 6600));
  localparam int              SUM_W     = 29;
  localparam int              D3_W      = 29;

  // cosine and sine magnitude of one quarter-wave angle
  typedef struct packed {
    logic [AMP_W-1:0] cos_amp;
    logic [AMP_W-1:0] sin_amp;
  } amp_pair_t;

  // q.61 fixed point used to build the table
  localparam int          FRAC      = 61;
  localparam logic [63:0] ONE_Q     = 64'd1 << FRAC;
  localparam logic [63:0] HALF_PI_Q = 64'h3243F6A8885A308D;
  localparam int          TERMS     = 27;

  // (a*b) >> s, kept to 64 bits
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> s);
  endfunction

  // round(32767 * v / 2^61), ties upward, clamped to full scale
  function automatic logic [AMP_W-1:0] to_amp(logic [63:0] v);
    logic [127:0] p;
    logic [127:0] m;
    p = {64'd0, v} * 128'd32767 + (128'd1 << (FRAC - 1));
    m = p >> FRAC;
    if (m > 128'd32767) begin
      m = 128'd32767;
    end
    return AMP_W'(m);
  endfunction

  // taylor series of cos and sin for quarter-wave step r out of 2^qsh
  function automatic amp_pair_t quarter_amps(logic [63:0] r, int qsh);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] c;
    logic [63:0] s;
    amp_pair_t   res;
    x = mul_shr(r, HALF_PI_Q, qsh);
    t = ONE_Q;
    c = ONE_Q;
    s = 64'd0;
    for (int n = 1; n <= TERMS; n++) begin
      t = mul_shr(t, x, FRAC) / 64'(n);
      case (n % 4)
        0: c = c + t;
        1: s = s + t;
        2: c = c - t;
        default: s = s - t;
      endcase
    end
    if (c[63]) begin
      c = 64'd0;
    end
    if (s[63]) begin
      s = 64'd0;
    end
    res.cos_amp = to_amp(c);
    res.sin_amp = to_amp(s);
    return res;
  endfunction

endpackage

// ----- src/cdac_cos_rom.sv -----
// quarter-wave cosine and sine amplitude rom with registered read
module cdac_cos_rom #(
  parameter int PHASE_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [PHASE_BITS-3:0]     addr,
  output cdac_pkg::amp_pair_t       amps
);

  localparam int QBITS = PHASE_BITS - 2;
  localparam int DEPTH = 1 << QBITS;

  cdac_pkg::amp_pair_t rom [DEPTH];

  // table contents, filled once before the first clock
  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      rom[i] = cdac_pkg::quarter_amps(64'(i), QBITS);
    end
  end

  // registered read, held while the stage is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      amps <= rom[addr];
    end
  end

endmodule

// ----- src/cosine_dac_code_generator_core.sv -----
// top level: pipelined cosine dac code generator
//
// Input channel: in_valid / in_stall with time_us, one timestamp per beat.
// Output channel: out_valid / out_stall with dac_code and clipped, one result
// per input beat, in order.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 is the frequency in centihertz, 1 the trough level
// and 2 the peak level in millivolts; other indexes are ignored. Write only
// while no beat is in flight.
// The pipeline takes one beat per cycle while in_stall is low; its stages are
// the phase product, two reciprocal-multiply divisions by the period, the
// cosine rom read, the signed offsets, the level scaling, a reciprocal-multiply
// division by the code denominator and the saturation.
// When the receiver stalls, the result holds on the output register and
// upstream stages keep filling empty slots; in_stall rises once every stage
// holds a beat.
// Reset clears all stage valid bits and loads the default frequency and levels.
module cosine_dac_code_generator_core #(
  parameter int CODE_BITS  = 12,
  parameter int PHASE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cdac_pkg::TIME_W-1:0]     time_us,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [CODE_BITS-1:0]            dac_code,
  output logic                            clipped,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cdac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdac_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NS      = 16;
  localparam int PROD_W  = cdac_pkg::FREQ_W + cdac_pkg::TIME_W;
  localparam int Q1_W    = PROD_W - cdac_pkg::MOD_LOW_BITS;
  localparam int REM_W   = cdac_pkg::REM_W;
  localparam int PW      = cdac_pkg::PERIOD_W;
  localparam int RS      = cdac_pkg::RECIP_SHIFT;
  localparam int PR_W    = PHASE_BITS + 6;
  localparam int LV_W    = cdac_pkg::MV_W + cdac_pkg::UPDN_W;
  localparam int SUM_W   = cdac_pkg::SUM_W;
  localparam int NW      = SUM_W + CODE_BITS + 1;
  localparam int NT_W    = NW - cdac_pkg::DEN_LOW_BITS;
  localparam int RE_W    = CODE_BITS + 3;
  localparam int D3_W    = cdac_pkg::D3_W;
  localparam int DW      = cdac_pkg::DEN_W;
  localparam int UW      = cdac_pkg::UPDN_W;

  localparam logic [63:0]     PH_RECIP64 = (64'd1 << (PHASE_BITS + RS)) / 64'd100000000;
  localparam logic [PR_W-1:0] PH_RECIP   = PR_W'(PH_RECIP64);
  localparam logic [RE_W-1:0] MAXC       = RE_W'((1 << CODE_BITS) - 1);

  // configuration registers
  logic [cdac_pkg::FREQ_W-1:0] freq;
  logic [cdac_pkg::MV_W-1:0]   low_mv;
  logic [cdac_pkg::MV_W-1:0]   high_mv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq    <= cdac_pkg::FREQ_RESET;
      low_mv  <= cdac_pkg::LOW_RESET;
      high_mv <= cdac_pkg::HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cdac_pkg::CFG_FREQ: freq    <= cfg_data[cdac_pkg::FREQ_W-1:0];
        cdac_pkg::CFG_LOW:  low_mv  <= cfg_data[cdac_pkg::MV_W-1:0];
        cdac_pkg::CFG_HIGH: high_mv <= cfg_data[cdac_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage load enables; a stage loads when it or any
  // stage after it is empty, or the output beat is taken
  logic [NS-1:0] v;
  logic [NS-1:0] load;

  for (genvar k = 0; k < NS; k++) begin : g_load
    assign load[k] = !out_stall || !(&v[NS-1:k]);
  end

  assign in_stall  = !load[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (load[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (load[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0: frequency times time
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      prod <= PROD_W'(freq) * PROD_W'(time_us);
    end
  end

  // stage 1: quotient estimate of the period modulo from the top bits
  logic [Q1_W+RS-1:0] q1_full;
  logic [Q1_W-1:0]    q1;
  logic [REM_W-1:0]   prod_b;

  assign q1_full = (Q1_W+RS)'(prod[PROD_W-1 -: Q1_W]) * (Q1_W+RS)'(cdac_pkg::MOD_RECIP);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      q1     <= q1_full[RS +: Q1_W];
      prod_b <= prod[REM_W-1:0];
    end
  end

  // stage 2: quotient times period, low bits only
  logic [Q1_W+PW-1:0] m1_full;
  logic [REM_W-1:0]   m1;
  logic [REM_W-1:0]   prod_c;

  assign m1_full = (Q1_W+PW)'(q1) * (Q1_W+PW)'(cdac_pkg::PERIOD);

  always_ff @(posedge clk) begin
    if (load[2]) begin
      m1     <= m1_full[REM_W-1:0];
      prod_c <= prod_b;
    end
  end

  // stage 3: remainder with one correction step
  logic [REM_W-1:0] r0;
  logic [PW-1:0]    frac_d;

  assign r0 = prod_c - m1;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      if (r0 >= REM_W'(cdac_pkg::PERIOD)) begin
        frac_d <= PW'(r0 - REM_W'(cdac_pkg::PERIOD));
      end else begin
        frac_d <= PW'(r0);
      end
    end
  end

  // stage 4: phase estimate by reciprocal of the period
  logic [PW+PR_W-1:0]     pe_full;
  logic [PHASE_BITS-1:0]  ph_est_e;
  logic [PW-1:0]          frac_e;

  assign pe_full = (PW+PR_W)'(frac_d) * (PW+PR_W)'(PH_RECIP);

  always_ff @(posedge clk) begin
    if (load[4]) begin
      ph_est_e <= pe_full[RS +: PHASE_BITS];
      frac_e   <= frac_d;
    end
  end

  // stage 5: phase estimate times period, low bits only
  logic [PHASE_BITS+PW-1:0] m2_full;
  logic [REM_W-1:0]         m2_f;
  logic [PHASE_BITS-1:0]    ph_est_f;
  logic [PW-1:0]            frac_f;

  assign m2_full = (PHASE_BITS+PW)'(ph_est_e) * (PHASE_BITS+PW)'(cdac_pkg::PERIOD);

  always_ff @(posedge clk) begin
    if (load[5]) begin
      m2_f     <= m2_full[REM_W-1:0];
      ph_est_f <= ph_est_e;
      frac_f   <= frac_e;
    end
  end

  // stage 6: phase correction
  logic [PW+PHASE_BITS-1:0] frac_sh;
  logic [REM_W-1:0]         d2;
  logic [PHASE_BITS-1:0]    ph_g;

  assign frac_sh = {frac_f, {PHASE_BITS{1'b0}}};
  assign d2      = frac_sh[REM_W-1:0] - m2_f;

  always_ff @(posedge clk) begin
    if (load[6]) begin
      ph_g <= ph_est_f + PHASE_BITS'(d2 >= REM_W'(cdac_pkg::PERIOD));
    end
  end

  // stage 7: quarter-wave rom read, quadrant travels alongside
  cdac_pkg::amp_pair_t amps_h;
  logic [1:0]          quad_h;

  cdac_cos_rom #(
    .PHASE_BITS(PHASE_BITS)
  ) u_rom (
    .clk (clk),
    .en  (load[7]),
    .addr(ph_g[PHASE_BITS-3:0]),
    .amps(amps_h)
  );

  always_ff @(posedge clk) begin
    if (load[7]) begin
      quad_h <= ph_g[PHASE_BITS-1 -: 2];
    end
  end

  // stage 8: signed amplitude as offsets above and below full scale
  logic [cdac_pkg::AMP_W-1:0] mag;
  logic                       neg;
  logic [UW-1:0]              up_i;
  logic [UW-1:0]              dn_i;

  assign mag = (quad_h == 2'd0 || quad_h == 2'd2) ? amps_h.cos_amp : amps_h.sin_amp;
  assign neg = (quad_h == 2'd1 || quad_h == 2'd2);

  always_ff @(posedge clk) begin
    if (load[8]) begin
      if (neg) begin
        up_i <= cdac_pkg::AMP_FULL - UW'(mag);
        dn_i <= cdac_pkg::AMP_FULL + UW'(mag);
      end else begin
        up_i <= cdac_pkg::AMP_FULL + UW'(mag);
        dn_i <= cdac_pkg::AMP_FULL - UW'(mag);
      end
    end
  end

  // stage 9: level scaling
  logic [LV_W-1:0] hp_j;
  logic [LV_W-1:0] lp_j;

  always_ff @(posedge clk) begin
    if (load[9]) begin
      hp_j <= LV_W'(high_mv) * LV_W'(up_i);
      lp_j <= LV_W'(low_mv) * LV_W'(dn_i);
    end
  end

  // stage 10: weighted level sum
  logic [SUM_W-1:0] sum_k;

  always_ff @(posedge clk) begin
    if (load[10]) begin
      sum_k <= SUM_W'(hp_j) + SUM_W'(lp_j);
    end
  end

  // stage 11: times full code, plus half the denominator for rounding
  logic [NW-1:0] n2_l;

  always_ff @(posedge clk) begin
    if (load[11]) begin
      n2_l <= NW'({sum_k, {CODE_BITS{1'b0}}}) - NW'(sum_k) + NW'(cdac_pkg::HALF_DEN);
    end
  end

  // stage 12: code estimate by reciprocal of the denominator
  logic [NT_W+RS-1:0] rp_full;
  logic [RE_W-1:0]    raw_est_m;
  logic [D3_W-1:0]    n2_m;

  assign rp_full = (NT_W+RS)'(n2_l[NW-1 -: NT_W]) * (NT_W+RS)'(cdac_pkg::DEN_RECIP);

  always_ff @(posedge clk) begin
    if (load[12]) begin
      raw_est_m <= rp_full[RS +: RE_W];
      n2_m      <= n2_l[D3_W-1:0];
    end
  end

  // stage 13: estimate times denominator, low bits only
  logic [RE_W+DW-1:0] m3_full;
  logic [D3_W-1:0]    m3_n;
  logic [RE_W-1:0]    raw_est_n;
  logic [D3_W-1:0]    n2_n;

  assign m3_full = (RE_W+DW)'(raw_est_m) * (RE_W+DW)'(cdac_pkg::DEN);

  always_ff @(posedge clk) begin
    if (load[13]) begin
      m3_n      <= m3_full[D3_W-1:0];
      raw_est_n <= raw_est_m;
      n2_n      <= n2_m;
    end
  end

  // stage 14: code correction
  logic [D3_W-1:0] d3;
  logic [RE_W-1:0] raw_o;

  assign d3 = n2_n - m3_n;

  always_ff @(posedge clk) begin
    if (load[14]) begin
      raw_o <= raw_est_n + RE_W'(d3 >= D3_W'(cdac_pkg::DEN));
    end
  end

  // stage 15: saturation into the output register
  always_ff @(posedge clk) begin
    if (load[15]) begin
      if (raw_o > MAXC) begin
        dac_code <= MAXC[CODE_BITS-1:0];
        clipped  <= 1'b1;
      end else begin
        dac_code <= raw_o[CODE_BITS-1:0];
        clipped  <= 1'b0;
      end
    end
  end

endmodule
